>>> design/mae_pkg.sv
`timescale 1ns / 1ps

package mae_pkg;

   typedef logic [7:0] byte_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_FOUND         = 2'd0,
      STATUS_NO_HEADER_END = 2'd1,
      STATUS_NO_GROUP      = 2'd2
   } status_type;

   localparam byte_type CH_LF = 8'd10;
   localparam byte_type CH_CR = 8'd13;
   localparam byte_type CH_SP = 8'd32;
   localparam byte_type CH_0  = 8'd48;
   localparam byte_type CH_2  = 8'd50;
   localparam byte_type CH_3  = 8'd51;
   localparam byte_type CH_9  = 8'd57;
   localparam byte_type CH_A  = 8'd65;

   localparam int unsigned ALT_WIDTH   = 12;
   localparam int unsigned PRESS_WIDTH = 18;

   // Valid range of a found altimeter group and its pressure
   localparam logic [ALT_WIDTH-1:0]   ALT_MIN   = 12'd2000;
   localparam logic [ALT_WIDTH-1:0]   ALT_MAX   = 12'd3999;
   localparam logic [PRESS_WIDTH-1:0] PRESS_MIN = 18'd67728;
   localparam logic [PRESS_WIDTH-1:0] PRESS_MAX = 18'd135422;

endpackage

>>> design/mae_if.sv
`timescale 1ns / 1ps

interface mae_req_if;
   logic                 valid;
   logic                 ready;
   mae_pkg::byte_type    data_byte;
   logic                 last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mae_rsp_if;
   logic                                  valid;
   logic                                  ready;
   mae_pkg::status_type                   status;
   logic [mae_pkg::ALT_WIDTH-1:0]         altimeter_hundredths_inhg;
   logic [mae_pkg::PRESS_WIDTH-1:0]       pressure_centi_hpa;

   modport source (output valid, status, altimeter_hundredths_inhg, pressure_centi_hpa,
                   input ready);
   modport sink   (input valid, status, altimeter_hundredths_inhg, pressure_centi_hpa,
                   output ready);
endinterface

>>> design/metar_altimeter_extractor.sv
`timescale 1ns / 1ps
// Throughput: one byte item per cycle, sustained, whenever the result side is not stalled.
// Result path: the result item for the byte item that decides it passes through three registered
//   stages in order: decision, scaling multiply, and divide-by-constant multiply.
// Reset (synchronous, active high) clears the parser state and empties the result stages;
//   no clearing pass, the block takes items in the first cycle after reset.

module metar_altimeter_extractor #(
   parameter int unsigned MAX_TEXT_BYTES = 511
) (
   input  logic       clock,
   input  logic       reset,
   mae_req_if.sink    req_chan,
   mae_rsp_if.source  rsp_chan
);

   localparam int unsigned CntWidth  = 10;
   localparam int unsigned ProdWidth = 31;
   localparam int unsigned QuotWidth = 27;
   localparam int unsigned RecWidth  = 28;
   localparam int unsigned RecShift  = 37;
   localparam int unsigned MulWidth  = QuotWidth + RecWidth;

   localparam logic [CntWidth-1:0]  MaxBytes  = CntWidth'(MAX_TEXT_BYTES);
   localparam logic [2:0]           HdrDone   = 3'd4;
   // pressure = floor((value * 338639 + 5000) / 10000)
   localparam logic [ProdWidth-1:0] PressMult = 31'd338639;
   localparam logic [ProdWidth-1:0] PressBias = 31'd5000;
   // divide by 10000: shift right by 4, then multiply by ceil(2^37 / 625)
   localparam logic [RecWidth-1:0]  Recip625  = 28'd219902326;

   typedef enum logic [2:0] {
      TOK_IDLE  = 3'd0,
      TOK_SPACE = 3'd1,
      TOK_A     = 3'd2,
      TOK_D1    = 3'd3,
      TOK_D2    = 3'd4,
      TOK_D3    = 3'd5,
      TOK_D4    = 3'd6
   } tok_type;

   // Parser state
   logic [2:0]                        hdr_ff, hdr_in;
   logic                              body_ff, body_in;
   tok_type                           tok_ff, tok_in;
   logic [mae_pkg::ALT_WIDTH-1:0]     digit_ff, digit_in;
   logic [CntWidth-1:0]               cnt_ff, cnt_in;
   logic                              ans_ff, ans_in;

   // Result stage 1: decision
   logic                              valid1_ff, valid1_in;
   mae_pkg::status_type               status1_ff, status1_in;
   logic [mae_pkg::ALT_WIDTH-1:0]     value1_ff, value1_in;

   // Result stage 2: scaled product
   logic                              valid2_ff;
   mae_pkg::status_type               status2_ff;
   logic [mae_pkg::ALT_WIDTH-1:0]     value2_ff;
   logic [ProdWidth-1:0]              prod2_ff, prod2_in;

   // Result stage 3: output register
   logic                              valid3_ff;
   mae_pkg::status_type               status3_ff;
   logic [mae_pkg::ALT_WIDTH-1:0]     value3_ff;
   logic [mae_pkg::PRESS_WIDTH-1:0]   press3_ff, press3_in;
   logic [MulWidth-1:0]               quot_full;

   logic adv1, adv2, adv3;
   logic accept;

   // Each stage loads when it is empty or the stage after it moves on
   assign adv3   = !valid3_ff || rsp_chan.ready;
   assign adv2   = !valid2_ff || adv3;
   assign adv1   = !valid1_ff || adv2;
   assign accept = req_chan.valid && adv1;

   assign req_chan.ready = adv1;

   assign rsp_chan.valid                     = valid3_ff;
   assign rsp_chan.status                    = status3_ff;
   assign rsp_chan.altimeter_hundredths_inhg = value3_ff;
   assign rsp_chan.pressure_centi_hpa        = press3_ff;

   // Parser: header search, then altimeter group search in the body
   always_comb begin
      mae_pkg::byte_type b;
      logic              last;
      logic              is_digit;
      logic              fail;
      logic              found;
      logic              ended;
      logic [mae_pkg::ALT_WIDTH+3:0] acc;

      b        = req_chan.data_byte;
      last     = req_chan.last_byte;
      is_digit = (b >= mae_pkg::CH_0) && (b <= mae_pkg::CH_9);
      fail     = 1'b0;
      found    = 1'b0;
      ended    = 1'b0;
      acc      = 16'(digit_ff) * 16'd10 + 16'(b[3:0]);

      hdr_in     = hdr_ff;
      body_in    = body_ff;
      tok_in     = tok_ff;
      digit_in   = digit_ff;
      cnt_in     = cnt_ff;
      ans_in     = ans_ff;
      valid1_in  = 1'b0;
      status1_in = mae_pkg::STATUS_FOUND;
      value1_in  = '0;

      if (accept) begin
         if (ans_ff) begin
            // Drop bytes after the answer; the last one starts a new response
            if (last) begin
               hdr_in   = '0;
               body_in  = 1'b0;
               tok_in   = TOK_IDLE;
               digit_in = '0;
               cnt_in   = '0;
               ans_in   = 1'b0;
            end
         end else begin
            if (b == 8'd0) begin
               ended = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (!body_ff) begin
                  // Header pattern alternates CR, LF
                  if (b == (hdr_ff[0] ? mae_pkg::CH_LF : mae_pkg::CH_CR)) begin
                     hdr_in = hdr_ff + 3'd1;
                  end else begin
                     hdr_in = (b == mae_pkg::CH_CR) ? 3'd1 : 3'd0;
                  end
                  if (hdr_in == HdrDone) begin
                     body_in  = 1'b1;
                     tok_in   = TOK_IDLE;
                     digit_in = '0;
                  end
               end else begin
                  fail = 1'b1;
                  case (tok_ff)
                     TOK_SPACE: begin
                        if (b == mae_pkg::CH_A) begin
                           tok_in = TOK_A;
                           fail   = 1'b0;
                        end
                     end
                     TOK_A: begin
                        if (b == mae_pkg::CH_2 || b == mae_pkg::CH_3) begin
                           digit_in = mae_pkg::ALT_WIDTH'(b[3:0]);
                           tok_in   = TOK_D1;
                           fail     = 1'b0;
                        end
                     end
                     TOK_D1, TOK_D2, TOK_D3: begin
                        if (is_digit) begin
                           digit_in = acc[mae_pkg::ALT_WIDTH-1:0];
                           tok_in   = tok_type'(tok_ff + 3'd1);
                           fail     = 1'b0;
                        end
                     end
                     TOK_D4: begin
                        if (b == mae_pkg::CH_SP || b == mae_pkg::CH_CR ||
                            b == mae_pkg::CH_LF) begin
                           found = 1'b1;
                           fail  = 1'b0;
                        end
                     end
                     default: begin
                        fail = 1'b1;
                     end
                  endcase
                  // Restart the search at the failing byte
                  if (fail) begin
                     tok_in = (b == mae_pkg::CH_SP) ? TOK_SPACE : TOK_IDLE;
                  end
               end
               if (last || cnt_in >= MaxBytes) begin
                  ended = 1'b1;
               end
            end

            // Four digits right at the end of the text count as found
            if (!found && ended && body_in && tok_in == TOK_D4) begin
               found = 1'b1;
            end

            if (found || ended) begin
               valid1_in  = 1'b1;
               status1_in = found   ? mae_pkg::STATUS_FOUND :
                            body_in ? mae_pkg::STATUS_NO_GROUP :
                                      mae_pkg::STATUS_NO_HEADER_END;
               value1_in  = found ? digit_in : '0;
               if (last) begin
                  hdr_in   = '0;
                  body_in  = 1'b0;
                  tok_in   = TOK_IDLE;
                  digit_in = '0;
                  cnt_in   = '0;
                  ans_in   = 1'b0;
               end else begin
                  ans_in = 1'b1;
               end
            end
         end
      end
   end

   // Scale to centi-hPa: one multiply per stage
   assign prod2_in  = ProdWidth'(ProdWidth'(value1_ff) * PressMult + PressBias);
   assign quot_full = MulWidth'(prod2_ff[ProdWidth-1:4]) * MulWidth'(Recip625);
   assign press3_in = quot_full[RecShift+mae_pkg::PRESS_WIDTH-1:RecShift];

   // Control state: parser and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff    <= '0;
         body_ff   <= 1'b0;
         tok_ff    <= TOK_IDLE;
         digit_ff  <= '0;
         cnt_ff    <= '0;
         ans_ff    <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         hdr_ff   <= hdr_in;
         body_ff  <= body_in;
         tok_ff   <= tok_in;
         digit_ff <= digit_in;
         cnt_ff   <= cnt_in;
         ans_ff   <= ans_in;
         if (adv1) begin
            valid1_ff <= valid1_in;
         end
         if (adv2) begin
            valid2_ff <= valid1_ff;
         end
         if (adv3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   // Payload: advance with the stage valids, hold while stalled
   always_ff @(posedge clock) begin
      if (adv1) begin
         status1_ff <= status1_in;
         value1_ff  <= value1_in;
      end
      if (adv2) begin
         status2_ff <= status1_ff;
         value2_ff  <= value1_ff;
         prod2_ff   <= prod2_in;
      end
      if (adv3) begin
         status3_ff <= status2_ff;
         value3_ff  <= value2_ff;
         press3_ff  <= press3_in;
      end
   end

endmodule

>>> design/mae_checker.sv
`timescale 1ns / 1ps

module mae_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input mae_pkg::status_type               rsp_status,
   input logic [mae_pkg::ALT_WIDTH-1:0]     rsp_altimeter,
   input logic [mae_pkg::PRESS_WIDTH-1:0]   rsp_pressure
);

   // Hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_altimeter) && $stable(rsp_pressure))
      else $error("stalled result item changed");

   // No result item right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A found group is four digits starting with 2 or 3, with matching pressure range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mae_pkg::STATUS_FOUND |->
         rsp_altimeter >= mae_pkg::ALT_MIN && rsp_altimeter <= mae_pkg::ALT_MAX &&
         rsp_pressure >= mae_pkg::PRESS_MIN && rsp_pressure <= mae_pkg::PRESS_MAX)
      else $error("found result out of range");

   // Not-found results carry zero payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mae_pkg::STATUS_FOUND |->
         rsp_altimeter == '0 && rsp_pressure == '0)
      else $error("not-found result with nonzero payload");

endmodule

bind metar_altimeter_extractor mae_checker u_mae_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_altimeter (rsp_chan.altimeter_hundredths_inhg),
   .rsp_pressure  (rsp_chan.pressure_centi_hpa)
);

>>> tb/sv/metar_altimeter_checker.sv
`timescale 1ns / 1ps

module metar_altimeter_checker #(
   parameter int unsigned MAX_TEXT_BYTES = 511
) (
   input  logic        clock,
   input  logic        reset,
   mae_req_if          req_mon,
   mae_rsp_if          rsp_mon,
   output int unsigned mismatches,
   output int unsigned readings_pending
);

   import mae_pkg::*;

   localparam byte_type CH_NUL = 8'd0;
   localparam byte_type BLANK_LINE [4] = '{CH_CR, CH_LF, CH_CR, CH_LF};

   // Progress through the altimeter group " Adddd"
   localparam logic [2:0] POS_IDLE         = 3'd0;
   localparam logic [2:0] POS_SPACE        = 3'd1;
   localparam logic [2:0] POS_LETTER       = 3'd2;
   localparam logic [2:0] POS_ONE_DIGIT    = 3'd3;
   localparam logic [2:0] POS_TWO_DIGITS   = 3'd4;
   localparam logic [2:0] POS_THREE_DIGITS = 3'd5;
   localparam logic [2:0] POS_FOUR_DIGITS  = 3'd6;

   typedef struct packed {
      status_type             status;
      logic [ALT_WIDTH-1:0]   alt;
      logic [PRESS_WIDTH-1:0] press;
   } reading_type;

   reading_type readings_due[$];
   reading_type due;
   reading_type fresh;

   logic [2:0]           crlf_matched;
   logic                 body_seen;
   logic [2:0]           group_pos;
   logic [ALT_WIDTH-1:0] group_digits;
   logic [9:0]           text_bytes;
   logic                 reply_done;

   function automatic void clear_parse();
      crlf_matched = '0;
      body_seen    = 1'b0;
      group_pos    = POS_IDLE;
      group_digits = '0;
      text_bytes   = '0;
      reply_done   = 1'b0;
   endfunction

   function automatic void scan_header(input byte_type b);
      logic [2:0] p;
      p = crlf_matched;
      if (p < 3'd4 && b == BLANK_LINE[p[1:0]]) begin
         p = p + 3'd1;
      end else begin
         p = (b == CH_CR) ? 3'd1 : 3'd0;
      end
      crlf_matched = p;
      if (p == 3'd4) begin
         body_seen    = 1'b1;
         group_pos    = POS_IDLE;
         group_digits = '0;
      end
   endfunction

   // Advance the group match; true when the byte terminates four digits.
   function automatic logic scan_body(input byte_type b);
      logic is_digit;
      logic matched;
      logic found;
      is_digit = (b >= CH_0 && b <= CH_9);
      matched  = 1'b0;
      found    = 1'b0;
      case (group_pos)
         POS_SPACE: begin
            if (b == CH_A) begin
               group_pos = POS_LETTER;
               matched   = 1'b1;
            end
         end
         POS_LETTER: begin
            if (b == CH_2 || b == CH_3) begin
               group_digits = ALT_WIDTH'(b - CH_0);
               group_pos    = POS_ONE_DIGIT;
               matched      = 1'b1;
            end
         end
         POS_ONE_DIGIT, POS_TWO_DIGITS, POS_THREE_DIGITS: begin
            if (is_digit) begin
               group_digits = ALT_WIDTH'(group_digits * 10 + (b - CH_0));
               group_pos    = group_pos + 3'd1;
               matched      = 1'b1;
            end
         end
         POS_FOUR_DIGITS: begin
            if (b == CH_SP || b == CH_CR || b == CH_LF) begin
               found   = 1'b1;
               matched = 1'b1;
            end
         end
         default: ;
      endcase
      if (!matched) group_pos = (b == CH_SP) ? POS_SPACE : POS_IDLE;
      return found;
   endfunction

   // Take one byte item; true when it decides the reading for this reply.
   function automatic logic take_byte(input byte_type b, input logic is_last,
                                      output reading_type r);
      logic found;
      logic ended;
      found = 1'b0;
      ended = 1'b0;
      r     = '0;
      if (reply_done) begin
         if (is_last) clear_parse();
         return 1'b0;
      end
      if (b == CH_NUL) begin
         ended = 1'b1;
      end else begin
         text_bytes = text_bytes + 10'd1;
         if (!body_seen) scan_header(b);
         else found = scan_body(b);
         if (is_last || text_bytes >= MAX_TEXT_BYTES) ended = 1'b1;
      end
      if (!found && !ended) return 1'b0;
      if (!found && body_seen && group_pos == POS_FOUR_DIGITS) found = 1'b1;
      if (found) begin
         r.status = STATUS_FOUND;
         r.alt    = group_digits;
         r.press  = PRESS_WIDTH'((longint'(group_digits) * 338639 + 5000) / 10000);
      end else if (body_seen) begin
         r.status = STATUS_NO_GROUP;
      end else begin
         r.status = STATUS_NO_HEADER_END;
      end
      if (is_last) clear_parse();
      else reply_done = 1'b1;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         readings_due.delete();
         mismatches = 0;
         readings_pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (readings_due.size() == 0) begin
               $error("result with no reading due: status %0d alt %0d press %0d",
                      rsp_mon.status, rsp_mon.altimeter_hundredths_inhg,
                      rsp_mon.pressure_centi_hpa);
               mismatches = mismatches + 1;
            end else begin
               due = readings_due.pop_front();
               if (rsp_mon.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_mon.status);
                  mismatches = mismatches + 1;
               end
               if (rsp_mon.altimeter_hundredths_inhg !== due.alt) begin
                  $error("altimeter_hundredths_inhg: expected %0d, got %0d",
                         due.alt, rsp_mon.altimeter_hundredths_inhg);
                  mismatches = mismatches + 1;
               end
               if (rsp_mon.pressure_centi_hpa !== due.press) begin
                  $error("pressure_centi_hpa: expected %0d, got %0d",
                         due.press, rsp_mon.pressure_centi_hpa);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (take_byte(req_mon.data_byte, req_mon.last_byte, fresh)) begin
               readings_due.push_back(fresh);
            end
         end
         readings_pending <= readings_due.size();
      end
   end

endmodule

>>> tb/sv/metar_altimeter_extractor_test.sv
`timescale 1ns / 1ps

module metar_altimeter_extractor_test;

   import mae_pkg::*;

   localparam int unsigned TEXT_LIMIT   = 511;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RESULT_HOLD  = 240;
   localparam int unsigned RANDOM_BYTES = 2000;
   localparam int unsigned MIN_REPLIES  = 8;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam byte_type    CH_NUL       = 8'd0;

   // Kinds of reply text built for the random part
   typedef enum int {
      SHAPE_PLAIN,
      SHAPE_BROKEN,
      SHAPE_HEADLESS,
      SHAPE_NUL_END,
      SHAPE_NOISE,
      SHAPE_TRAILING_DIGITS,
      SHAPE_LIMIT_DIGITS,
      SHAPE_LIMIT_OVER
   } reply_shape_type;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count;
   int unsigned readings_pending;

   // Handshake knobs for the sender (send_idling) and the receiver (rsp_idling, hold_request)
   bit          send_idling;
   bit          rsp_idling;
   bit          hold_request;

   byte_type        reply_text[$];
   int unsigned     sent_bytes;
   int unsigned     replies;
   reply_shape_type shape;

   mae_req_if req_chan();
   mae_rsp_if rsp_chan();

   metar_altimeter_extractor #(
      .MAX_TEXT_BYTES (TEXT_LIMIT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   metar_altimeter_checker #(
      .MAX_TEXT_BYTES (TEXT_LIMIT)
   ) reading_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatches       (mismatch_count),
      .readings_pending (readings_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Give up on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: one ready decision per cycle. A hold request stalls the
   // result channel so the block backs up into its input.
   initial begin
      int unsigned hold_left;
      int unsigned stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            hold_left    = RESULT_HOLD;
            hold_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (rsp_idling && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   // Text builders: append to reply_text
   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) reply_text.push_back(byte_type'(s[i]));
   endtask

   // Any byte but NUL; keep spaces out when asked so no group can start
   task automatic put_noise(input int unsigned count, input bit spaces_ok);
      byte_type b;
      repeat (count) begin
         b = byte_type'($urandom_range(1, 255));
         if (!spaces_ok && b == CH_SP) b = b + 8'd1;
         reply_text.push_back(b);
      end
   endtask

   task automatic put_printable(input int unsigned count);
      repeat (count) reply_text.push_back(byte_type'($urandom_range(32, 126)));
   endtask

   // Header lines joined by CR LF, with the occasional decoy CR LF CR
   task automatic put_headers(input bit complete);
      int unsigned lines;
      lines = $urandom_range(0, 4);
      for (int i = 0; i < lines; i++) begin
         if ($urandom_range(0, 5) == 0) put_text("\r\n\r");
         if ($urandom_range(0, 7) == 0) put_noise($urandom_range(1, 6), 1'b1);
         put_printable($urandom_range(1, 20));
         if (i < lines - 1) put_text("\r\n");
      end
      if (complete) put_text("\r\n\r\n");
      else put_text("\r\n");
   endtask

   task automatic put_group();
      put_text($sformatf(" A%0d", $urandom_range(2000, 3999)));
      case ($urandom_range(0, 2))
         0:       reply_text.push_back(CH_SP);
         1:       reply_text.push_back(CH_CR);
         default: reply_text.push_back(CH_LF);
      endcase
   endtask

   // Near misses: wrong first digit, short, five digits, lower case, split
   task automatic put_broken_group();
      int unsigned d;
      case ($urandom_range(0, 4))
         0: begin
            d = $urandom_range(0, 7);
            if (d >= 2) d = d + 2;
            put_text($sformatf(" A%0d%0d ", d, $urandom_range(100, 999)));
         end
         1: put_text($sformatf(" A%0dx ", $urandom_range(20, 399)));
         2: put_text($sformatf(" A%0d%0d ", $urandom_range(2000, 3999), $urandom_range(0, 9)));
         3: put_text($sformatf(" a%0d ", $urandom_range(2000, 3999)));
         default: put_text($sformatf(" A %0d ", $urandom_range(2000, 3999)));
      endcase
   endtask

   task automatic put_words(input int unsigned count, input bit groups_ok);
      int unsigned r;
      repeat (count) begin
         r = $urandom_range(0, 9);
         if (r < 4) begin
            reply_text.push_back(byte_type'($urandom_range(33, 126)));
            put_printable($urandom_range(0, 7));
            reply_text.push_back(CH_SP);
         end else if (r == 4) begin
            put_noise($urandom_range(1, 4), 1'b1);
         end else if (r < 7 || !groups_ok) begin
            put_broken_group();
         end else begin
            put_group();
         end
      end
   endtask

   // Offer one byte item, with an optional idle gap in front
   task automatic send_item(input byte_type b, input logic is_last);
      if (send_idling && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= is_last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Send the built text, marking its final byte, then drop it
   task automatic send_reply();
      foreach (reply_text[i]) send_item(reply_text[i], i == reply_text.size() - 1);
      sent_bytes = sent_bytes + reply_text.size();
      reply_text.delete();
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      send_idling        = 1'b0;
      rsp_idling         = 1'b0;
      hold_request       = 1'b0;
      sent_bytes         = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed replies
      send_idling = 1'b1;
      rsp_idling  = 1'b1;

      // found on the space, trailing bytes ignored until last
      put_text("\r\n\r\n A2992 xyz");
      send_reply();
      // NUL as the only byte: no header end
      reply_text.push_back(CH_NUL);
      send_reply();
      // header end on the final byte: empty body
      put_text("HTTP\r\n\r\n");
      send_reply();
      // four digits closed by the last byte, highest value
      put_text("\r\n\r\n A3999");
      send_reply();
      // four digits closed by NUL, lowest value, junk after it
      put_text("\r\n\r\nX A2000");
      reply_text.push_back(CH_NUL);
      put_text("junk");
      send_reply();
      // CR and LF as terminators
      put_text("\r\n\r\n A3000\r");
      send_reply();
      put_text("\r\n\r\nQ A2500\nmore");
      send_reply();
      // wrong digit, then a good group
      put_text("\r\n\r\n A1992 A2992 ");
      send_reply();
      // header end interrupted by a second CR, then completed
      put_text("a\r\n\ra\r\r\n\r\n  A3010 ");
      send_reply();
      // body without a valid group
      put_text("\r\n\r\nhello A 2992 A29921\n");
      send_reply();
      // headers never end
      put_text("abc\r\n\r");
      send_reply();
      // all ones byte alone
      reply_text.push_back(8'hFF);
      send_reply();

      // Stall the result side while short replies keep arriving
      send_idling  = 1'b0;
      rsp_idling   = 1'b0;
      hold_request = 1'b1;
      repeat (24) begin
         put_text($sformatf("\r\n\r\n A%0d\n", $urandom_range(2000, 3999)));
         send_reply();
      end

      // Random replies, mostly well formed
      replies = 0;
      while (sent_bytes < RANDOM_BYTES || replies < MIN_REPLIES) begin
         if (replies == 3) shape = SHAPE_LIMIT_DIGITS;
         else if (replies == 7) shape = SHAPE_LIMIT_OVER;
         else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9: shape = SHAPE_PLAIN;
               10, 11:                       shape = SHAPE_BROKEN;
               12:                           shape = SHAPE_HEADLESS;
               13, 14:                       shape = SHAPE_NUL_END;
               15:                           shape = SHAPE_NOISE;
               16, 17:                       shape = SHAPE_TRAILING_DIGITS;
               18:                           shape = SHAPE_LIMIT_DIGITS;
               default:                      shape = SHAPE_LIMIT_OVER;
            endcase
         end
         // leave some replies with no idling at all
         send_idling = ($urandom_range(0, 3) != 0);
         rsp_idling  = ($urandom_range(0, 3) != 0);

         case (shape)
            SHAPE_PLAIN: begin
               put_headers(1'b1);
               put_words($urandom_range(1, 6), 1'b1);
            end
            SHAPE_BROKEN: begin
               put_headers(1'b1);
               put_words($urandom_range(0, 6), 1'b0);
            end
            SHAPE_HEADLESS: begin
               put_headers(1'b0);
               put_printable($urandom_range(0, 10));
            end
            SHAPE_NUL_END: begin
               put_headers(1'b1);
               put_words($urandom_range(0, 4), 1'b1);
               reply_text.push_back(CH_NUL);
               put_noise($urandom_range(0, 4), 1'b1);
            end
            SHAPE_NOISE: begin
               put_noise($urandom_range(1, 30), 1'b1);
               if ($urandom_range(0, 2) == 0) begin
                  reply_text.push_back(CH_NUL);
                  put_noise($urandom_range(0, 3), 1'b1);
               end
            end
            SHAPE_TRAILING_DIGITS: begin
               put_headers(1'b1);
               put_words($urandom_range(0, 4), 1'b0);
               put_text($sformatf(" A%0d", $urandom_range(2000, 3999)));
               if ($urandom_range(0, 1) == 0) reply_text.push_back(CH_NUL);
            end
            SHAPE_LIMIT_DIGITS: begin
               // last digit lands exactly on the byte limit
               put_text("\r\n\r\n");
               put_noise(TEXT_LIMIT - 10, 1'b0);
               put_text($sformatf(" A%0d", $urandom_range(2000, 3999)));
               put_noise($urandom_range(0, 3), 1'b1);
            end
            default: begin
               // run past the limit; sometimes the last byte is the limit byte
               put_text("\r\n\r\n");
               put_noise(TEXT_LIMIT - 4 + $urandom_range(0, 40), 1'b1);
            end
         endcase
         send_reply();
         replies = replies + 1;
      end
      req_chan.valid <= 1'b0;

      // Let the final prediction land, then drain the results
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
